// ===== rtl/sect_pkg.sv =====
// ----------------------------------------------------------------------------
// sect_pkg: shared types, constants and helpers of the strip edge tracker
// Mode and action codes, register indexes, and the structs that travel
// between the top level and the evaluation logic.
// ----------------------------------------------------------------------------
package sect_pkg;

    localparam int SURFACES   = 2;
    localparam int POS_W      = 17;
    localparam int CALC_W     = 21;
    localparam int SKIP_W     = 10;
    localparam int INWARD_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int RANGE_W    = 15;
    localparam int WIDTH_W    = 17;
    localparam int SKIPF_W    = 8;

    // reciprocal of 5, exact for dividends below 2**18
    localparam logic [16:0] RECIP5       = 17'd52429;
    localparam int          RECIP5_SHIFT = 18;
    // reciprocal of 10, exact for dividends below 2**22
    localparam logic [20:0] RECIP10       = 21'd1677722;
    localparam int          RECIP10_SHIFT = 24;
    localparam int          CENTRE_Q_W    = 18;

    localparam logic [RANGE_W-1:0] DETECT_RESET   = 15'd1000;
    localparam logic [RANGE_W-1:0] RECOVERY_RESET = 15'd2000;
    localparam logic [RANGE_W-1:0] WIDTH_TOL_RESET = 15'd500;
    localparam logic [RANGE_W-1:0] PREV_TOL_RESET = 15'd500;
    localparam logic [WIDTH_W-1:0] CW_MAX_RESET   = 17'd30000;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_BACK   = 3'd1,
        MODE_SKIP   = 3'd2,
        MODE_OK     = 3'd3,
        MODE_ONE    = 3'd4,
        MODE_CENTRE = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ACT_FRAME       = 2'd0,
        ACT_COIL_CHANGE = 2'd1,
        ACT_COIL_START  = 2'd2,
        ACT_COIL_END    = 2'd3
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PASSTHROUGH  = 3'd0,
        CFG_CAM_ADJUST   = 3'd1,
        CFG_DETECT_RANGE = 3'd2,
        CFG_RECOVERY     = 3'd3,
        CFG_WIDTH_TOL    = 3'd4,
        CFG_PREV_TOL     = 3'd5,
        CFG_SKIP_FRAMES  = 3'd6,
        CFG_CW_MAX       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                passthrough;
        logic                cam_adjust;
        logic [RANGE_W-1:0]  detect_range;
        logic [RANGE_W-1:0]  recovery_range;
        logic [RANGE_W-1:0]  width_tol;
        logic [RANGE_W-1:0]  prev_tol;
        logic [WIDTH_W-1:0]  coil_width_max;
        logic [INWARD_W-1:0] inward;
    } cfg_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [POS_W-1:0]  last_left;
        logic signed [POS_W-1:0]  last_right;
        logic [WIDTH_W-1:0]       exp_width;
        logic signed [SKIP_W-1:0] skip_count;
    } surf_state_t;

    typedef struct packed {
        mode_t                   mode;
        logic signed [POS_W-1:0] fin_left;
        logic signed [POS_W-1:0] fin_right;
        logic                    usable;
        logic                    consistent;
        logic [3:0]              faults;
        logic                    changed;
    } eval_result_t;

    function automatic logic signed [CALC_W-1:0] sext_calc(input logic signed [POS_W-1:0] v);
        return {{(CALC_W-POS_W){v[POS_W-1]}}, v};
    endfunction

    function automatic logic [CALC_W-1:0] abs_calc(input logic signed [CALC_W-1:0] v);
        logic [CALC_W-1:0] r;
        r = v[CALC_W-1] ? CALC_W'(-v) : CALC_W'(v);
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [CALC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > $signed(21'sd65535))
        begin
            r = 17'sh0FFFF;
        end
        else if (v < $signed(-21'sd65536))
        begin
            r = 17'sh10000;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // (d + 2) / 5, the inward shift of the estimated edge
    function automatic logic [INWARD_W-1:0] inward_of(input logic [RANGE_W-1:0] d);
        logic [RANGE_W:0]     x;
        logic [2*RANGE_W+2:0] p;
        x = {1'b0, d} + (RANGE_W+1)'(2);
        p = {17'b0, x} * {16'b0, RECIP5};
        return p[RECIP5_SHIFT +: INWARD_W];
    endfunction

endpackage

// ===== rtl/sect_eval.sv =====
// ----------------------------------------------------------------------------
// sect_eval: edge mode decision for one frame
// Window, width and previous-edge checks, one-edge estimate and the
// line-centre fallback, all in one combinational pass.
// ----------------------------------------------------------------------------
module sect_eval (
    input  sect_pkg::cfg_t                           cfg,
    input  sect_pkg::surf_state_t                    st,
    input  logic signed [sect_pkg::POS_W-1:0]        left_edge,
    input  logic signed [sect_pkg::POS_W-1:0]        right_edge,
    output sect_pkg::eval_result_t                   res,
    output logic signed [sect_pkg::SKIP_W-1:0]       skip_next
);

    localparam int CW = sect_pkg::CALC_W;

    logic                  en_l;
    logic                  en_r;
    logic signed [CW-1:0]  raw_l;
    logic signed [CW-1:0]  raw_r;
    logic signed [CW-1:0]  last_l;
    logic signed [CW-1:0]  last_r;
    logic signed [CW-1:0]  w_s;
    logic                  width_known;
    logic                  fault_l;
    logic                  fault_r;
    logic                  width_bad;
    logic signed [CW-1:0]  mw;
    logic signed [CW-1:0]  tol_s;
    logic [CW-1:0]         dl;
    logic [CW-1:0]         dr;
    logic [CW-1:0]         pt_u;
    logic                  near_ok;
    logic signed [CW-1:0]  inward_s;
    logic signed [CW-1:0]  one_l;
    logic signed [CW-1:0]  one_r;
    logic signed [CW-1:0]  v;
    logic [CW-1:0]         mag;
    logic [CW-1:0]         x;
    logic [2*CW-1:0]       prod;
    logic [sect_pkg::CENTRE_Q_W-1:0] q;
    logic signed [CW-1:0]  q_s;
    logic signed [CW-1:0]  ctr_r;
    logic                  ctr_zero;
    sect_pkg::mode_t       mode;
    logic signed [CW-1:0]  fin_l;
    logic signed [CW-1:0]  fin_r;
    logic [3:0]            faults;
    logic                  consistent;

    assign en_l   = left_edge[sect_pkg::POS_W-1];
    assign en_r   = !right_edge[sect_pkg::POS_W-1] && (right_edge != '0);
    assign raw_l  = en_l ? sect_pkg::sext_calc(left_edge) : '0;
    assign raw_r  = en_r ? sect_pkg::sext_calc(right_edge) : '0;
    assign last_l = sect_pkg::sext_calc(st.last_left);
    assign last_r = sect_pkg::sext_calc(st.last_right);
    assign w_s    = $signed({{(CW-sect_pkg::WIDTH_W){1'b0}}, st.exp_width});
    assign width_known = (st.exp_width != '0);

    assign skip_next = (st.skip_count > 0) ? st.skip_count - sect_pkg::SKIP_W'(1)
                                           : st.skip_count;

    // window tests in doubled units
    assign fault_l = !en_l || (sect_pkg::abs_calc(-w_s - (raw_l <<< 1))
                     > {{(CW-sect_pkg::RANGE_W){1'b0}}, cfg.detect_range});
    assign fault_r = !en_r || (sect_pkg::abs_calc(w_s - (raw_r <<< 1))
                     > {{(CW-sect_pkg::RANGE_W){1'b0}}, cfg.detect_range});

    assign tol_s     = $signed({{(CW-sect_pkg::RANGE_W){1'b0}}, cfg.width_tol});
    assign mw        = raw_r - raw_l;
    assign width_bad = (mw < w_s - tol_s) || (mw > w_s + tol_s);

    assign dl      = sect_pkg::abs_calc(last_l - raw_l);
    assign dr      = sect_pkg::abs_calc(last_r - raw_r);
    assign pt_u    = {{(CW-sect_pkg::RANGE_W){1'b0}}, cfg.prev_tol};
    assign near_ok = (en_l && ({dl[CW-2:0], 1'b0} <= pt_u))
                  || (en_r && ({dr[CW-2:0], 1'b0} <= pt_u));

    assign inward_s = $signed({{(CW-sect_pkg::INWARD_W){1'b0}}, cfg.inward});
    assign one_l    = (dl <= dr) ? raw_l : raw_r - w_s + inward_s;
    assign one_r    = (dl <= dr) ? raw_l + w_s - inward_s : raw_r;

    // centre: round((5w - 4r) / 10), halves away from zero, left mirrors right
    assign v    = (w_s <<< 2) + w_s
                - $signed({{(CW-sect_pkg::RANGE_W-2){1'b0}}, cfg.recovery_range, 2'b00});
    assign mag  = sect_pkg::abs_calc(v);
    assign x    = mag + CW'(5);
    assign prod = {{CW{1'b0}}, x} * {{CW{1'b0}}, sect_pkg::RECIP10};
    assign q    = prod[sect_pkg::RECIP10_SHIFT +: sect_pkg::CENTRE_Q_W];
    assign q_s  = $signed({{(CW-sect_pkg::CENTRE_Q_W){1'b0}}, q});
    assign ctr_r = v[CW-1] ? -q_s : q_s;
    assign ctr_zero = !width_known || (st.exp_width >= cfg.coil_width_max);

    always_comb
    begin
        mode       = st.mode;
        fin_l      = raw_l;
        fin_r      = raw_r;
        faults     = 4'b0000;
        consistent = en_l && en_r;
        if (cfg.passthrough)
        begin
            consistent = 1'b1;
        end
        else
        begin
            if (cfg.cam_adjust)
            begin
                mode = sect_pkg::MODE_NONE;
                if (!en_l) fin_l = last_l;
                if (!en_r) fin_r = last_r;
            end
            else if (!width_known)
            begin
                if (st.mode == sect_pkg::MODE_NONE)
                begin
                    mode = (en_l && en_r) ? sect_pkg::MODE_BACK : sect_pkg::MODE_NONE;
                end
                else
                begin
                    mode = sect_pkg::MODE_BACK;
                    if (!en_l) fin_l = last_l;
                    if (!en_r) fin_r = last_r;
                end
            end
            else if (skip_next != '0)
            begin
                mode = sect_pkg::MODE_SKIP;
                if (!en_l) fin_l = last_l;
                if (!en_r) fin_r = last_r;
            end
            else
            begin
                faults[0] = fault_l;
                faults[1] = fault_r;
                if (fault_l || fault_r)
                begin
                    mode = sect_pkg::MODE_ONE;
                end
                else if (width_bad)
                begin
                    mode      = sect_pkg::MODE_ONE;
                    faults[2] = 1'b1;
                end
                else
                begin
                    mode = sect_pkg::MODE_OK;
                end
            end

            if (mode == sect_pkg::MODE_ONE)
            begin
                consistent = 1'b0;
                if ((st.mode != sect_pkg::MODE_SKIP) && near_ok)
                begin
                    fin_l = one_l;
                    fin_r = one_r;
                end
                else
                begin
                    mode      = sect_pkg::MODE_CENTRE;
                    faults[3] = 1'b1;
                    fin_l     = ctr_zero ? '0 : -ctr_r;
                    fin_r     = ctr_zero ? '0 : ctr_r;
                end
            end
        end
    end

    assign res.mode       = mode;
    assign res.fin_left   = sect_pkg::sat_pos(fin_l);
    assign res.fin_right  = sect_pkg::sat_pos(fin_r);
    assign res.usable     = !cfg.passthrough && ((mode == sect_pkg::MODE_OK)
                            || (mode == sect_pkg::MODE_ONE) || (mode == sect_pkg::MODE_CENTRE));
    assign res.consistent = consistent;
    assign res.faults     = faults;
    assign res.changed    = !cfg.passthrough && (mode != st.mode)
                            && (mode != sect_pkg::MODE_NONE);

endmodule

// ===== rtl/strip_edge_consistency_tracker.sv =====
// ----------------------------------------------------------------------------
// strip_edge_consistency_tracker: per-surface strip edge tracking
// Checks raw frame edges against the coil width and picks an edge mode.
// ----------------------------------------------------------------------------
// Each input transaction is either a frame (raw left/right edges) or a coil
// event (physical change, logical start, end) for one strip surface. Frames
// give exactly one output transaction: edge mode, final edges, usable and
// consistent flags, fault bits and a mode-changed flag; coil events only
// update that surface's state and give nothing. The block has an input
// register and a result register with the evaluation logic between them;
// a frame's result is registered as the frame leaves the input register, and
// a new transaction can be taken every cycle while the result register is
// free or being emptied; the per-surface state is written in the same cycle,
// so back-to-back frames on the same surface see each other. The rate is set
// by the single evaluation pass (window, width and previous edge checks plus
// the reciprocal multiply of the centre fallback). The input keeps taking
// transactions while a result waits, until the result register is full and
// a frame sits in the input register. No clearing pass after reset. The user
// must write registers through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
module strip_edge_consistency_tracker (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [sect_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sect_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: left_edge[16:0], right_edge[33:17], coil_width[50:34],
    // is_init[51], zero pad[55:52]
    input  logic [55:0] s_tdata,
    // tuser from bit 0: action[1:0], surface[2]
    input  logic [2:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: edge_mode[2:0], final_left[19:3], final_right[36:20],
    // answer_usable[37], edges_consistent[38], fault_bits[42:39],
    // mode_changed[43], zero pad[47:44]
    output logic [47:0] m_tdata
);

    // configuration registers
    logic                              passthrough_reg;
    logic                              cam_adjust_reg;
    logic [sect_pkg::RANGE_W-1:0]      detect_range_reg;
    logic [sect_pkg::RANGE_W-1:0]      recovery_range_reg;
    logic [sect_pkg::RANGE_W-1:0]      width_tol_reg;
    logic [sect_pkg::RANGE_W-1:0]      prev_tol_reg;
    logic [sect_pkg::SKIPF_W-1:0]      skip_frames_reg;
    logic [sect_pkg::WIDTH_W-1:0]      cw_max_reg;
    logic [sect_pkg::INWARD_W-1:0]     inward_reg;

    // input register
    logic                              in_vld_reg;
    sect_pkg::act_t                    in_action_reg;
    logic                              in_surface_reg;
    logic signed [sect_pkg::POS_W-1:0] in_left_reg;
    logic signed [sect_pkg::POS_W-1:0] in_right_reg;
    logic [sect_pkg::WIDTH_W-1:0]      in_width_reg;
    logic                              in_init_reg;

    // per-surface state
    sect_pkg::mode_t                    mode_store_reg [sect_pkg::SURFACES];
    logic signed [sect_pkg::POS_W-1:0]  last_left_reg  [sect_pkg::SURFACES];
    logic signed [sect_pkg::POS_W-1:0]  last_right_reg [sect_pkg::SURFACES];
    logic [sect_pkg::WIDTH_W-1:0]       exp_width_reg  [sect_pkg::SURFACES];
    logic signed [sect_pkg::SKIP_W-1:0] skip_count_reg [sect_pkg::SURFACES];

    // result register
    logic                              out_vld_reg;
    sect_pkg::eval_result_t            out_res_reg;

    sect_pkg::cfg_t                    cfg;
    sect_pkg::surf_state_t             cur_state;
    sect_pkg::eval_result_t            eval_res;
    logic signed [sect_pkg::SKIP_W-1:0] skip_next;
    logic [sect_pkg::SKIP_W-1:0]       skip_load;
    logic [sect_pkg::WIDTH_W-1:0]      width_next;
    logic                              surf_ok;
    logic                              makes_result;
    logic                              advance;

    // ------------------------------------------------------------------------
    // configuration; the inward shift ((detect_range + 2) / 5) is kept ready
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            passthrough_reg    <= 1'b0;
            cam_adjust_reg     <= 1'b0;
            detect_range_reg   <= sect_pkg::DETECT_RESET;
            recovery_range_reg <= sect_pkg::RECOVERY_RESET;
            width_tol_reg      <= sect_pkg::WIDTH_TOL_RESET;
            prev_tol_reg       <= sect_pkg::PREV_TOL_RESET;
            skip_frames_reg    <= '0;
            cw_max_reg         <= sect_pkg::CW_MAX_RESET;
            inward_reg         <= sect_pkg::inward_of(sect_pkg::DETECT_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sect_pkg::CFG_PASSTHROUGH:  passthrough_reg    <= cfg_data[0];
                    sect_pkg::CFG_CAM_ADJUST:   cam_adjust_reg     <= cfg_data[0];
                    sect_pkg::CFG_DETECT_RANGE:
                    begin
                        detect_range_reg <= cfg_data[sect_pkg::RANGE_W-1:0];
                        inward_reg       <= sect_pkg::inward_of(cfg_data[sect_pkg::RANGE_W-1:0]);
                    end
                    sect_pkg::CFG_RECOVERY:     recovery_range_reg <= cfg_data[sect_pkg::RANGE_W-1:0];
                    sect_pkg::CFG_WIDTH_TOL:    width_tol_reg      <= cfg_data[sect_pkg::RANGE_W-1:0];
                    sect_pkg::CFG_PREV_TOL:     prev_tol_reg       <= cfg_data[sect_pkg::RANGE_W-1:0];
                    sect_pkg::CFG_SKIP_FRAMES:  skip_frames_reg    <= cfg_data[sect_pkg::SKIPF_W-1:0];
                    sect_pkg::CFG_CW_MAX:       cw_max_reg         <= cfg_data[sect_pkg::WIDTH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg.passthrough    = passthrough_reg;
    assign cfg.cam_adjust     = cam_adjust_reg;
    assign cfg.detect_range   = detect_range_reg;
    assign cfg.recovery_range = recovery_range_reg;
    assign cfg.width_tol      = width_tol_reg;
    assign cfg.prev_tol       = prev_tol_reg;
    assign cfg.coil_width_max = cw_max_reg;
    assign cfg.inward         = inward_reg;

    // ------------------------------------------------------------------------
    // flow control: the input stage moves on when its transaction gives no
    // result or the result register is free or being emptied
    // ------------------------------------------------------------------------
    assign surf_ok      = (32'(in_surface_reg) < sect_pkg::SURFACES);
    assign makes_result = (in_action_reg == sect_pkg::ACT_FRAME) && surf_ok;
    assign advance      = in_vld_reg && (!makes_result || !out_vld_reg || m_tready);
    assign s_tready     = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg  <= sect_pkg::act_t'(s_tuser[1:0]);
            in_surface_reg <= s_tuser[2];
            in_left_reg    <= s_tdata[16:0];
            in_right_reg   <= s_tdata[33:17];
            in_width_reg   <= s_tdata[50:34];
            in_init_reg    <= s_tdata[51];
        end
    end

    // ------------------------------------------------------------------------
    // evaluation of the frame in the input register
    // ------------------------------------------------------------------------
    assign cur_state.mode       = mode_store_reg[in_surface_reg];
    assign cur_state.last_left  = last_left_reg[in_surface_reg];
    assign cur_state.last_right = last_right_reg[in_surface_reg];
    assign cur_state.exp_width  = exp_width_reg[in_surface_reg];
    assign cur_state.skip_count = skip_count_reg[in_surface_reg];

    sect_eval u_eval (
        .cfg        (cfg),
        .st         (cur_state),
        .left_edge  (in_left_reg),
        .right_edge (in_right_reg),
        .res        (eval_res),
        .skip_next  (skip_next)
    );

    // coil start: dead-zone length is skip_frames + 1 unless zero
    assign skip_load  = (skip_frames_reg == '0) ? '0
                      : {{(sect_pkg::SKIP_W-sect_pkg::SKIPF_W){1'b0}}, skip_frames_reg}
                        + sect_pkg::SKIP_W'(1);
    // widths of zero or at/above the limit count as unknown
    assign width_next = ((in_width_reg == '0) || (in_width_reg >= cw_max_reg))
                      ? '0 : in_width_reg;

    // ------------------------------------------------------------------------
    // per-surface state update
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sect_pkg::SURFACES; i++)
            begin
                mode_store_reg[i] <= sect_pkg::MODE_NONE;
                last_left_reg[i]  <= '0;
                last_right_reg[i] <= '0;
                exp_width_reg[i]  <= '0;
                skip_count_reg[i] <= '0;
            end
        end
        else if (advance && surf_ok)
        begin
            case (in_action_reg)
                sect_pkg::ACT_FRAME:
                begin
                    mode_store_reg[in_surface_reg] <= eval_res.mode;
                    last_left_reg[in_surface_reg]  <= eval_res.fin_left;
                    last_right_reg[in_surface_reg] <= eval_res.fin_right;
                    skip_count_reg[in_surface_reg] <= skip_next;
                end
                sect_pkg::ACT_COIL_CHANGE:
                begin
                    // held in skip until the next logical start
                    skip_count_reg[in_surface_reg] <= -sect_pkg::SKIP_W'(1);
                end
                sect_pkg::ACT_COIL_START:
                begin
                    exp_width_reg[in_surface_reg] <= width_next;
                    if (!in_init_reg)
                    begin
                        skip_count_reg[in_surface_reg] <= $signed(skip_load);
                    end
                end
                sect_pkg::ACT_COIL_END:
                begin
                    exp_width_reg[in_surface_reg] <= '0;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && makes_result)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && makes_result)
        begin
            out_res_reg <= eval_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000,
                       out_res_reg.changed,
                       out_res_reg.faults,
                       out_res_reg.consistent,
                       out_res_reg.usable,
                       out_res_reg.fin_right,
                       out_res_reg.fin_left,
                       out_res_reg.mode};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_frame_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && makes_result) |=> m_tvalid)
        else $error("frame left the input stage without a result");

    a_mode_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && makes_result) |=>
            (mode_store_reg[$past(in_surface_reg)] == out_res_reg.mode))
        else $error("stored mode differs from delivered mode");

    a_taken_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_vld_reg)
        else $error("accepted transaction lost in the input stage");

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_surface_reg)))
        else $error("input stage changed while blocked");

    generate
        for (genvar g = 0; g < sect_pkg::SURFACES; g++)
        begin : g_skip_chk
            a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
                (skip_count_reg[g] >= -sect_pkg::SKIP_W'(1)))
                else $error("skip count below hold value");
        end
    endgenerate

endmodule

// ===== bench/edge_track_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_track_checker: result predictor and scoreboard for the edge tracker
// Watches the register port and both streams, keeps its own copy of the
// per-surface tracking state, and compares every result with the oldest
// expected one.
// ----------------------------------------------------------------------------
module edge_track_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // left_edge, right_edge, coil_width, is_init, zero pad
    input  logic [55:0] s_tdata,
    // action, surface
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // edge_mode, final_left, final_right, answer_usable, edges_consistent,
    // fault_bits, mode_changed, zero pad
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);
    import sect_pkg::*;

    // register shadow
    bit pass_on;
    bit cam_on;
    int det_rng;
    int rec_rng;
    int wid_tol;
    int prev_tol;
    int skip_len;
    int cw_limit;

    // per-surface tracking state
    mode_t mode_mem    [SURFACES];
    int    hold_left   [SURFACES];
    int    hold_right  [SURFACES];
    int    coil_w      [SURFACES];
    bit    coil_w_known[SURFACES];
    int    dead_frames [SURFACES];

    eval_result_t edge_results_q[$];

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp17(input longint v);
        if (v > 65535)
        begin
            return 65535;
        end
        if (v < -65536)
        begin
            return -65536;
        end
        return v;
    endfunction

    // divide by ten, halves away from zero
    function automatic longint round_tenth(input longint v);
        if (v >= 0)
        begin
            return (v + 5) / 10;
        end
        return -((-v + 5) / 10);
    endfunction

    function automatic void predict_frame(input int sf, input logic signed [16:0] l_in,
                                          input logic signed [16:0] r_in);
        bit           en_l;
        bit           en_r;
        bit           usable;
        bit           agree;
        bit           changed;
        longint       raw_l;
        longint       raw_r;
        longint       fin_l;
        longint       fin_r;
        longint       w;
        longint       dl;
        longint       dr;
        longint       mw;
        longint       inward;
        mode_t        prev_mode;
        mode_t        new_mode;
        logic [3:0]   faults;
        eval_result_t res;
        en_l      = (l_in < 0);
        en_r      = (r_in > 0);
        raw_l     = en_l ? longint'(l_in) : 0;
        raw_r     = en_r ? longint'(r_in) : 0;
        agree     = en_l && en_r;
        prev_mode = mode_mem[sf];
        w         = coil_w[sf];
        faults    = 4'd0;
        usable    = 1'b0;
        changed   = 1'b0;
        if (dead_frames[sf] > 0)
        begin
            dead_frames[sf]--;
        end
        fin_l    = raw_l;
        fin_r    = raw_r;
        new_mode = prev_mode;

        if (pass_on)
        begin
            agree = 1'b1;
        end
        else
        begin
            if (cam_on)
            begin
                new_mode = MODE_NONE;
                if (!en_l) fin_l = hold_left[sf];
                if (!en_r) fin_r = hold_right[sf];
            end
            else if (!coil_w_known[sf])
            begin
                if (prev_mode == MODE_NONE)
                begin
                    new_mode = agree ? MODE_BACK : MODE_NONE;
                end
                else
                begin
                    new_mode = MODE_BACK;
                    if (!en_l) fin_l = hold_left[sf];
                    if (!en_r) fin_r = hold_right[sf];
                end
            end
            else if (dead_frames[sf] != 0)
            begin
                new_mode = MODE_SKIP;
                if (!en_l) fin_l = hold_left[sf];
                if (!en_r) fin_r = hold_right[sf];
            end
            else
            begin
                // window test in doubled units
                if (!en_l || magnitude(-w - 2 * raw_l) > det_rng) faults[0] = 1'b1;
                if (!en_r || magnitude(w - 2 * raw_r) > det_rng) faults[1] = 1'b1;
                if (faults != 4'd0)
                begin
                    new_mode = MODE_ONE;
                end
                else
                begin
                    mw = magnitude(raw_l) + magnitude(raw_r);
                    if (mw < w - wid_tol || mw > w + wid_tol)
                    begin
                        new_mode  = MODE_ONE;
                        faults[2] = 1'b1;
                    end
                    else
                    begin
                        new_mode = MODE_OK;
                    end
                end
            end

            if (new_mode == MODE_ONE)
            begin
                dl    = magnitude(hold_left[sf] - raw_l);
                dr    = magnitude(hold_right[sf] - raw_r);
                agree = 1'b0;
                if (prev_mode != MODE_SKIP &&
                    ((en_l && 2 * dl <= prev_tol) || (en_r && 2 * dr <= prev_tol)))
                begin
                    // estimate the far edge from the nearer one
                    inward = (det_rng + 2) / 5;
                    if (dl <= dr)
                    begin
                        fin_l = raw_l;
                        fin_r = raw_l + w - inward;
                    end
                    else
                    begin
                        fin_r = raw_r;
                        fin_l = raw_r - w + inward;
                    end
                end
                else
                begin
                    new_mode = MODE_CENTRE;
                    if (w <= 0 || w >= cw_limit)
                    begin
                        fin_l = 0;
                        fin_r = 0;
                    end
                    else
                    begin
                        fin_l = round_tenth(-5 * w + 4 * longint'(rec_rng));
                        fin_r = round_tenth(5 * w - 4 * longint'(rec_rng));
                    end
                    faults[3] = 1'b1;
                end
            end
            usable  = (new_mode == MODE_OK) || (new_mode == MODE_ONE) ||
                      (new_mode == MODE_CENTRE);
            changed = (new_mode != prev_mode) && (new_mode != MODE_NONE);
        end

        fin_l           = clamp17(fin_l);
        fin_r           = clamp17(fin_r);
        mode_mem[sf]    = new_mode;
        hold_left[sf]   = int'(fin_l);
        hold_right[sf]  = int'(fin_r);

        res.mode       = new_mode;
        res.fin_left   = fin_l[16:0];
        res.fin_right  = fin_r[16:0];
        res.usable     = usable;
        res.consistent = agree;
        res.faults     = faults;
        res.changed    = changed;
        edge_results_q.push_back(res);
    endfunction

    function automatic void take_item();
        act_t act;
        int   sf;
        int   cw;
        act = act_t'(s_tuser[1:0]);
        sf  = int'(s_tuser[2]);
        cw  = int'(s_tdata[50:34]);
        case (act)
            ACT_FRAME:
            begin
                predict_frame(sf, s_tdata[16:0], s_tdata[33:17]);
            end
            ACT_COIL_CHANGE:
            begin
                dead_frames[sf] = -1;
            end
            ACT_COIL_START:
            begin
                if (cw == 0 || cw >= cw_limit)
                begin
                    coil_w[sf]       = 0;
                    coil_w_known[sf] = 1'b0;
                end
                else
                begin
                    coil_w[sf]       = cw;
                    coil_w_known[sf] = 1'b1;
                end
                if (!s_tdata[51])
                begin
                    dead_frames[sf] = (skip_len == 0) ? 0 : skip_len + 1;
                end
            end
            default:
            begin
                coil_w[sf]       = 0;
                coil_w_known[sf] = 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        eval_result_t want;
        if (edge_results_q.size() == 0)
        begin
            $error("result transaction with nothing expected: %h", m_tdata);
            fail_count++;
        end
        else
        begin
            want = edge_results_q.pop_front();
            check_field("edge_mode", want.mode, m_tdata[2:0]);
            check_field("final_left", want.fin_left, $signed(m_tdata[19:3]));
            check_field("final_right", want.fin_right, $signed(m_tdata[36:20]));
            check_field("answer_usable", want.usable, m_tdata[37]);
            check_field("edges_consistent", want.consistent, m_tdata[38]);
            check_field("fault_bits", want.faults, m_tdata[42:39]);
            check_field("mode_changed", want.changed, m_tdata[43]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_on  = 1'b0;
            cam_on   = 1'b0;
            det_rng  = 1000;
            rec_rng  = 2000;
            wid_tol  = 500;
            prev_tol = 500;
            skip_len = 0;
            cw_limit = 30000;
            for (int s = 0; s < SURFACES; s++)
            begin
                mode_mem[s]     = MODE_NONE;
                hold_left[s]    = 0;
                hold_right[s]   = 0;
                coil_w[s]       = 0;
                coil_w_known[s] = 1'b0;
                dead_frames[s]  = 0;
            end
            edge_results_q.delete();
            outstanding = 0;
        end
        else
        begin
            // a register write takes effect for a transaction taken at the same edge
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PASSTHROUGH:  pass_on  = cfg_data[0];
                    CFG_CAM_ADJUST:   cam_on   = cfg_data[0];
                    CFG_DETECT_RANGE: det_rng  = int'(cfg_data[14:0]);
                    CFG_RECOVERY:     rec_rng  = int'(cfg_data[14:0]);
                    CFG_WIDTH_TOL:    wid_tol  = int'(cfg_data[14:0]);
                    CFG_PREV_TOL:     prev_tol = int'(cfg_data[14:0]);
                    CFG_SKIP_FRAMES:  skip_len = int'(cfg_data[7:0]);
                    default:          cw_limit = int'(cfg_data);
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (s_tvalid && s_tready)
            begin
                take_item();
            end
            outstanding = edge_results_q.size();
        end
    end

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the strip edge consistency tracker
// Drives coil events and frames on both surfaces through several register
// settings, with random idling on both streams; a separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import sect_pkg::*;

    // generous bound on the run length
    localparam int CYCLE_LIMIT = 400000;
    // cycles allowed for a coil event still inside the pipeline
    localparam int DRAIN_CYCLES = 6;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    // left_edge, right_edge, coil_width, is_init, zero pad
    logic [55:0] s_tdata;
    // action, surface
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // edge_mode, final_left, final_right, answer_usable, edges_consistent,
    // fault_bits, mode_changed, zero pad
    logic [47:0] m_tdata;

    int fail_count;
    int outstanding;
    int cycle_count;

    // no random idling on either stream while set
    bit calm;

    // register values last written, used to shape the frames
    int det_now;
    int wtol_now;

    strip_edge_consistency_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    edge_track_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // result side back-pressure, changed on the falling edge only
    always @(negedge clk)
    begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 29);
    end

    function automatic int rand17();
        return $urandom_range(0, 131071);
    endfunction

    function automatic int wobble(input int j);
        return int'($urandom_range(0, 2 * j)) - j;
    endfunction

    // one input transaction, with random idle cycles in front of it;
    // returns on the falling edge after the handshake
    task automatic send(input act_t act, input bit sf, input int left, input int right,
                        input int cw, input bit init);
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, init, cw[16:0], right[16:0], left[16:0]};
        s_tuser  <= {sf, act};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // stop sending until every result is back, then let coil events drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[16:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_config(input bit pass, input bit cam, input int det, input int rec,
                                input int wtol, input int ptol, input int skip, input int cwmax);
        settle();
        write_reg(CFG_PASSTHROUGH, pass);
        write_reg(CFG_CAM_ADJUST, cam);
        write_reg(CFG_DETECT_RANGE, det);
        write_reg(CFG_RECOVERY, rec);
        write_reg(CFG_WIDTH_TOL, wtol);
        write_reg(CFG_PREV_TOL, ptol);
        write_reg(CFG_SKIP_FRAMES, skip);
        write_reg(CFG_CW_MAX, cwmax);
        det_now  = det;
        wtol_now = wtol;
    endtask

    // mostly whole coils (change, start, frames near the expected edges,
    // sometimes an end), the rest random transactions of any kind
    task automatic run_coils(input int n);
        int done;
        int cw;
        int half;
        int j;
        int kind;
        int left;
        int right;
        bit sf;
        done = 0;
        while (done < n)
        begin
            sf = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    send(ACT_COIL_CHANGE, sf, rand17(), rand17(), rand17(),
                         1'($urandom_range(0, 1)));
                    done++;
                end
                kind = $urandom_range(0, 99);
                if (kind < 8)
                begin
                    cw = 0;
                end
                else if (kind < 18)
                begin
                    cw = rand17();
                end
                else
                begin
                    cw = $urandom_range(4000, 28000);
                end
                send(ACT_COIL_START, sf, rand17(), rand17(), cw, $urandom_range(0, 99) < 10);
                done++;
                half = cw / 2;
                j    = det_now / 4 + 1;
                repeat ($urandom_range(3, 14))
                begin
                    kind  = $urandom_range(0, 99);
                    left  = -half + wobble(j);
                    right = half + wobble(j);
                    if (kind >= 65 && kind < 75)
                    begin
                        // left edge scattered widely, mostly outside the window
                        left = -half + wobble(det_now + 3000);
                    end
                    else if (kind >= 75 && kind < 85)
                    begin
                        // right edge not found
                        right = -int'($urandom_range(0, 3000));
                    end
                    else if (kind >= 85 && kind < 92)
                    begin
                        // both edges pushed outward, the strip reads too wide
                        left  = -half - wtol_now / 2 - $urandom_range(1, 400);
                        right = half + wtol_now / 2 + $urandom_range(1, 400);
                    end
                    else if (kind >= 92)
                    begin
                        left  = int'($urandom_range(0, 80000)) - 40000;
                        right = int'($urandom_range(0, 80000)) - 40000;
                    end
                    send(ACT_FRAME, sf, left, right, rand17(), 1'($urandom_range(0, 1)));
                    done++;
                end
                if ($urandom_range(0, 99) < 30)
                begin
                    send(ACT_COIL_END, sf, rand17(), rand17(), rand17(),
                         1'($urandom_range(0, 1)));
                    done++;
                end
            end
            else
            begin
                send(act_t'(2'($urandom_range(0, 3))), sf, rand17(), rand17(), rand17(),
                     1'($urandom_range(0, 1)));
                done++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_PASSTHROUGH;
        cfg_data  = 17'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 56'd0;
        s_tuser   = 3'd0;
        m_tready  = 1'b0;
        calm      = 1'b0;
        det_now   = 1000;
        wtol_now  = 500;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, registers at their reset values
        // no coil width yet: backup once both edges show, then hold
        send(ACT_FRAME, 0, -10000, 10000, 0, 0);
        send(ACT_FRAME, 0, 5, -5, 0, 0);
        send(ACT_COIL_START, 0, 0, 0, 20000, 0);
        // clean frames
        send(ACT_FRAME, 0, -10000, 10000, 0, 0);
        send(ACT_FRAME, 0, -10100, 9950, 0, 0);
        // left outside its window, right close to last: one-edge estimate
        send(ACT_FRAME, 0, -12000, 10000, 0, 0);
        // width out of tolerance
        send(ACT_FRAME, 0, -10400, 10400, 0, 0);
        // both edges lost or far away: centre fallback
        send(ACT_FRAME, 0, -20000, 3000, 0, 0);
        send(ACT_FRAME, 0, 0, 0, 0, 0);
        // coil change holds skip until the next non start-up coil start
        send(ACT_COIL_CHANGE, 0, 0, 0, 0, 0);
        send(ACT_FRAME, 0, 0, 10000, 0, 0);
        send(ACT_COIL_START, 0, 0, 0, 20000, 1);
        send(ACT_FRAME, 0, -10000, 0, 0, 0);
        send(ACT_COIL_START, 0, 0, 0, 20000, 0);
        send(ACT_FRAME, 0, -10000, 10000, 0, 0);
        // coil end forgets the width
        send(ACT_COIL_END, 0, 0, 0, 0, 0);
        send(ACT_FRAME, 0, -9000, 0, 0, 0);
        // second surface: widths at the field limits and extreme edges
        send(ACT_COIL_START, 1, 0, 0, 131071, 0);
        send(ACT_FRAME, 1, -65536, 65535, 0, 1);
        send(ACT_COIL_START, 1, 0, 0, 0, 0);
        send(ACT_FRAME, 1, 65535, -65536, 0, 0);
        send(ACT_COIL_START, 1, 0, 0, 29999, 0);
        send(ACT_FRAME, 1, -15000, 15000, 0, 0);
        send(ACT_FRAME, 1, -1, 1, 0, 0);

        // random part, one register setting per phase
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: apply_config(0, 0, 1000, 2000, 500, 500, 0, 30000);
                1: apply_config(0, 0, $urandom_range(200, 4000), $urandom_range(0, 8000),
                                $urandom_range(100, 2000), $urandom_range(100, 4000),
                                $urandom_range(0, 4), $urandom_range(30000, 80000));
                2: apply_config(0, 0, 0, 32767, 0, 32767, 1, 131071);
                3: apply_config(0, 0, 32767, 0, 32767, 0, 255, 1);
                4: apply_config(1, 0, $urandom_range(200, 4000), $urandom_range(0, 8000),
                                $urandom_range(100, 2000), $urandom_range(100, 4000),
                                $urandom_range(0, 3), 30000);
                5: apply_config(0, 1, $urandom_range(200, 4000), $urandom_range(0, 8000),
                                $urandom_range(100, 2000), $urandom_range(100, 4000),
                                $urandom_range(0, 3), 30000);
                default: apply_config(0, 0, $urandom_range(500, 3000),
                                      $urandom_range(0, 8000), $urandom_range(200, 1500),
                                      $urandom_range(200, 3000), $urandom_range(0, 2),
                                      $urandom_range(25000, 60000));
            endcase
            // last phase runs at full rate on both streams
            calm = (phase == 6);
            run_coils(95);
            // hold the input until every result is back
            settle();
            run_coils(95);
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sect_pkg.sv
rtl/sect_eval.sv
rtl/strip_edge_consistency_tracker.sv
bench/edge_track_checker.sv
bench/testbench.sv
